// ===== design/hpq_pkg.sv =====
// Shared types and codes for the binary max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package hpq_pkg;

	localparam int KEY_W  = 31;
	localparam int TAG_W  = 16;
	localparam int SLOT_W = 11;
	localparam int CNT_W  = 11;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_PEEK   = 2'd2;
	localparam logic [1:0] OP_ADJUST = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rd_root;
		logic take_root;
		logic rd_child;
		logic step;
		logic place;
		logic hfy_init;
		logic rd_hfy;
		logic hfy_take;
		logic hfy_dec;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       last;
		logic       descend;
		logic       stop;
		logic       i_zero;
		logic       out_busy;
	} sts_t;

endpackage

// ===== design/max_heap_priority_queue.sv =====
// Binary max-heap priority queue: one item at a time, one result word per item.
// Each level descended by a delete, adjust or sift-down costs one read and one write of the store.
// A last-flagged load then heapifies the store with up to n/2 sift-downs.
// The next word can be taken in the cycle the result rises; an untaken result holds back the next result.
// Reset clears the entry count, the output valid flag and the controller; the store needs no clearing.
module max_heap_priority_queue #(
	parameter int DEPTH    = 1024,
	parameter int TAG_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [hpq_pkg::KEY_W-1:0]  key,
	input  logic [hpq_pkg::TAG_W-1:0]  tag,
	input  logic [hpq_pkg::SLOT_W-1:0] slot,
	input  logic                       first,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [hpq_pkg::KEY_W-1:0]  out_key,
	output logic [hpq_pkg::TAG_W-1:0]  out_tag,
	output logic [1:0]                 status,
	output logic [hpq_pkg::CNT_W-1:0]  count
);
	import hpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	hpq_dp #(
		.DEPTH   (DEPTH),
		.TAG_BITS(TAG_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.operation(operation),
		.key      (key),
		.tag      (tag),
		.slot     (slot),
		.first    (first),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_key  (out_key),
		.out_tag  (out_tag),
		.status   (status),
		.count    (count)
	);

endmodule

// ===== design/hpq_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module hpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== design/hpq_ctrl.sv =====
// Controller state machine of the heap: sequences load, delete, peek, adjust,
// sift-down and heapify. Depends on hpq_pkg.
module hpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hpq_pkg::sts_t sts,
	output hpq_pkg::cmd_t cmd
);
	import hpq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_ROOT   = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_HSTART = 4'd5;
	localparam logic [3:0] S_HTEST  = 4'd6;
	localparam logic [3:0] S_HLOAD  = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;

	logic [3:0] state_q, state_d;
	logic       hfy_q, hfy_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		hfy_d   = hfy_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_LOAD) begin
					state_d = sts.last ? S_HSTART : S_FINISH;
				end else if (sts.err) begin
					state_d = S_FINISH;
				end else if (sts.op == OP_ADJUST) begin
					state_d = S_CHECK;
				end else begin
					cmd.rd_root = 1'b1;
					state_d     = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.take_root = 1'b1;
				state_d       = (sts.op == OP_DELETE) ? S_CHECK : S_FINISH;
			end
			S_CHECK: begin
				if (sts.descend) begin
					cmd.rd_child = 1'b1;
					state_d      = S_CMP;
				end else begin
					cmd.place = 1'b1;
					if (hfy_q) begin
						cmd.hfy_dec = 1'b1;
						state_d     = S_HTEST;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_CMP: begin
				cmd.step = 1'b1;
				if (!sts.stop) begin
					state_d = S_CHECK;
				end else if (hfy_q) begin
					cmd.hfy_dec = 1'b1;
					state_d     = S_HTEST;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_HSTART: begin
				cmd.hfy_init = 1'b1;
				hfy_d        = 1'b1;
				state_d      = S_HTEST;
			end
			S_HTEST: begin
				if (sts.i_zero) begin
					hfy_d   = 1'b0;
					state_d = S_FINISH;
				end else begin
					cmd.rd_hfy = 1'b1;
					state_d    = S_HLOAD;
				end
			end
			S_HLOAD: begin
				cmd.hfy_take = 1'b1;
				state_d      = S_CHECK;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				hfy_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hfy_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			hfy_q   <= hfy_d;
		end
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DECODE)
		else $error("accepted word did not move the controller to decode");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("result emitted over an untaken word");

endmodule

// ===== design/hpq_dp.sv =====
// Datapath of the heap: entry count, sift position, moving entry, result
// registers and the heap store. Depends on hpq_pkg and hpq_ram.
module hpq_dp #(
	parameter int DEPTH    = 1024,
	parameter int TAG_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hpq_pkg::cmd_t               cmd,
	output hpq_pkg::sts_t               sts,
	input  logic [1:0]                  operation,
	input  logic [hpq_pkg::KEY_W-1:0]   key,
	input  logic [hpq_pkg::TAG_W-1:0]   tag,
	input  logic [hpq_pkg::SLOT_W-1:0]  slot,
	input  logic                        first,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hpq_pkg::KEY_W-1:0]   out_key,
	output logic [hpq_pkg::TAG_W-1:0]   out_tag,
	output logic [1:0]                  status,
	output logic [hpq_pkg::CNT_W-1:0]   count
);
	import hpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(DEPTH + 2);
	localparam int AW = $clog2(DEPTH);
	localparam int EW = KEY_W + TAG_BITS;
	localparam int SW = (PW > SLOT_W) ? PW : SLOT_W;

	logic [CW-1:0]    count_q, hfy_q, base;
	logic [PW-1:0]    pos_q, n_p, cl;
	logic [EW-1:0]    mov_q, in_ent, child;
	logic [1:0]       op_q, res_st_q, out_st_q;
	logic             last_q, err_q, out_valid_q;
	logic [KEY_W-1:0] res_key_q, out_key_q, key_a, key_b;
	logic [TAG_W-1:0] res_tag_q, out_tag_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             full, slot_bad, empty, sel_r, stop;

	logic          we;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [EW-1:0] wdata, rdata_a, rdata_b;

	assign in_ent   = {key, TAG_BITS'(tag)};
	assign base     = first ? '0 : count_q;
	assign full     = base >= CW'(DEPTH);
	assign slot_bad = (slot == '0) || (SW'(slot) > SW'(count_q));
	assign empty    = (count_q == '0);

	// Positions run from 1; the children of p sit at 2p and 2p+1.
	assign n_p   = PW'(count_q);
	assign cl    = pos_q << 1;
	assign key_a = rdata_a[EW-1 -: KEY_W];
	assign key_b = rdata_b[EW-1 -: KEY_W];
	assign sel_r = (cl != n_p) && (key_a < key_b);
	assign child = sel_r ? rdata_b : rdata_a;
	assign stop  = mov_q[EW-1 -: KEY_W] >= child[EW-1 -: KEY_W];

	always_comb begin
		we      = 1'b0;
		waddr   = '0;
		wdata   = mov_q;
		raddr_a = '0;
		raddr_b = '0;
		if (cmd.capture && operation == OP_LOAD && !full) begin
			we    = 1'b1;
			waddr = AW'(base);
			wdata = in_ent;
		end
		if (cmd.place) begin
			we    = 1'b1;
			waddr = AW'(pos_q - PW'(1));
		end
		if (cmd.step) begin
			we    = 1'b1;
			waddr = AW'(pos_q - PW'(1));
			wdata = stop ? mov_q : child;
		end
		if (cmd.rd_root) begin
			raddr_b = AW'(count_q - CW'(1));
		end
		if (cmd.rd_child) begin
			raddr_a = AW'(cl - PW'(1));
			raddr_b = AW'(cl);
		end
		if (cmd.rd_hfy) begin
			raddr_a = AW'(hfy_q - CW'(1));
		end
	end

	hpq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture && operation == OP_LOAD) begin
				count_q <= full ? base : base + CW'(1);
			end
			if (cmd.take_root && op_q == OP_DELETE) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			last_q    <= last;
			res_key_q <= '0;
			res_tag_q <= '0;
			mov_q     <= in_ent;
			pos_q     <= PW'(slot);
			case (operation)
				OP_LOAD: begin
					res_st_q <= full ? ST_FULL : ST_OK;
					err_q    <= full;
				end
				OP_DELETE, OP_PEEK: begin
					res_st_q <= empty ? ST_EMPTY : ST_OK;
					err_q    <= empty;
				end
				default: begin
					res_st_q <= slot_bad ? ST_RANGE : ST_OK;
					err_q    <= slot_bad;
				end
			endcase
		end
		if (cmd.take_root) begin
			res_key_q <= key_a;
			res_tag_q <= TAG_W'(rdata_a[TAG_BITS-1:0]);
			mov_q     <= rdata_b;
			pos_q     <= PW'(1);
		end
		if (cmd.hfy_init) begin
			hfy_q <= count_q >> 1;
		end
		if (cmd.hfy_take) begin
			mov_q <= rdata_a;
			pos_q <= PW'(hfy_q);
		end
		if (cmd.hfy_dec) begin
			hfy_q <= hfy_q - CW'(1);
		end
		if (cmd.step && !stop) begin
			pos_q <= sel_r ? cl + PW'(1) : cl;
		end
		if (cmd.emit) begin
			out_key_q <= res_key_q;
			out_tag_q <= res_tag_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= CNT_W'(count_q);
		end
	end

	assign sts.op       = op_q;
	assign sts.err      = err_q;
	assign sts.last     = last_q;
	assign sts.descend  = pos_q <= (n_p >> 1);
	assign sts.stop     = stop;
	assign sts.i_zero   = (hfy_q == '0);
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign status    = out_st_q;
	assign count     = out_cnt_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds the store depth");

	a_child_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_child |-> (pos_q != '0) && (cl <= n_p))
		else $error("child read outside the heap");

endmodule
